@@ rtl/slfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants for the split link frame receiver: frame
// position codes, frame event and result records, and the link constants.
// ----------------------------------------------------------------------------
package slfr_pkg;

   // field widths
   localparam int KEY_COUNT = 28;
   localparam int KEY_W     = 28;
   localparam int COUNT_W   = 24;
   localparam int WORD_W    = 32;

   // frame constants
   localparam logic [7:0] SYNC_BYTE = 8'hA5;
   localparam int VOL_UP_BIT   = 28;
   localparam int VOL_DOWN_BIT = 29;
   localparam int MUTE_BIT     = 30;

   // quiet counter limits
   localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] TIMEOUT_RESET = COUNT_W'(100000);

   // keys that the remote side may report
   localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_COUNT) - 64'd1);

   // item mode codes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // position inside a frame
   typedef enum logic [5:0] {
      POS_HUNT  = 6'b000001,
      POS_PAY0  = 6'b000010,
      POS_PAY1  = 6'b000100,
      POS_PAY2  = 6'b001000,
      POS_PAY3  = 6'b010000,
      POS_CHECK = 6'b100000
   } frame_pos_type;

   // outcome of a frame that ends on this item
   typedef struct packed {
      logic              ok;
      logic              err;
      logic [WORD_W-1:0] word;
   } frame_event_type;

   // one result item
   typedef struct packed {
      logic [KEY_W-1:0] key_bits;
      logic             frame_ok;
      logic             check_error;
      logic             volume_up;
      logic             volume_down;
      logic             mute_pulse;
      logic             link_lost;
   } result_type;

endpackage

@@ rtl/slfr_deframer.sv @@
// ----------------------------------------------------------------------------
// slfr_deframer
// Hunts for the sync byte, gathers four payload bytes with a running XOR and
// checks the closing check byte. Reports a good or bad frame for one item.
// ----------------------------------------------------------------------------
module slfr_deframer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     mode,
   input  logic [7:0]               rx_byte,
   output slfr_pkg::frame_event_type frame_event
);
   import slfr_pkg::*;

   frame_pos_type pos_ff, pos_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    payload_ff [4];
   logic          pay_we;
   logic [1:0]    pay_idx;
   logic          is_byte;

   assign is_byte = (mode == MODE_BYTE);

   // frame sequencing and check
   always_comb begin
      pos_in            = pos_ff;
      xor_in            = xor_ff;
      pay_we            = 1'b0;
      pay_idx           = 2'd0;
      frame_event.ok    = 1'b0;
      frame_event.err   = 1'b0;
      frame_event.word  = {payload_ff[3], payload_ff[2], payload_ff[1], payload_ff[0]};
      if (is_byte) begin
         case (pos_ff)
            POS_HUNT: begin
               if (rx_byte == SYNC_BYTE) begin
                  xor_in = rx_byte;
                  pos_in = POS_PAY0;
               end
            end
            POS_PAY0: begin
               pay_we  = 1'b1;
               pay_idx = 2'd0;
               xor_in  = xor_ff ^ rx_byte;
               pos_in  = POS_PAY1;
            end
            POS_PAY1: begin
               pay_we  = 1'b1;
               pay_idx = 2'd1;
               xor_in  = xor_ff ^ rx_byte;
               pos_in  = POS_PAY2;
            end
            POS_PAY2: begin
               pay_we  = 1'b1;
               pay_idx = 2'd2;
               xor_in  = xor_ff ^ rx_byte;
               pos_in  = POS_PAY3;
            end
            POS_PAY3: begin
               pay_we  = 1'b1;
               pay_idx = 2'd3;
               xor_in  = xor_ff ^ rx_byte;
               pos_in  = POS_CHECK;
            end
            POS_CHECK: begin
               frame_event.ok  = (rx_byte == xor_ff);
               frame_event.err = (rx_byte != xor_ff);
               xor_in          = 8'd0;
               pos_in          = POS_HUNT;
            end
            default: begin
               xor_in = 8'd0;
               pos_in = POS_HUNT;
            end
         endcase
      end
   end

   // position and running check
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         xor_ff <= 8'd0;
      end else if (step_en) begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
   end

   // payload bytes, each written before it is read
   always_ff @(posedge clock) begin
      if (step_en && pay_we) begin
         payload_ff[pay_idx] <= rx_byte;
      end
   end

   // a check byte always sends the hunt back to sync
   assert property (@(posedge clock) disable iff (reset)
      (step_en && is_byte && pos_ff == POS_CHECK) |=> (pos_ff == POS_HUNT))
      else $error("deframer did not return to hunt after check byte");

   // a frame cannot be both good and bad
   assert property (@(posedge clock) disable iff (reset)
      !(frame_event.ok && frame_event.err))
      else $error("frame flagged good and bad at once");

endmodule

@@ rtl/slfr_key_hold.sv @@
// ----------------------------------------------------------------------------
// slfr_key_hold
// Holds the remote key bits, runs the saturating quiet counter and the
// timeout register, and forms the result item for one step.
// ----------------------------------------------------------------------------
module slfr_key_hold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              mode,
   input  slfr_pkg::frame_event_type         frame_event,
   input  logic                              csr_we,
   input  logic [slfr_pkg::COUNT_W-1:0]      csr_wdata,
   output slfr_pkg::result_type              result
);
   import slfr_pkg::*;

   logic [COUNT_W-1:0] timeout_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0]   held_ff, held_in;
   logic               lost;

   // quiet counter: ticks count up and saturate, a good frame restarts it
   always_comb begin
      count_in = count_ff;
      if (mode == MODE_TICK) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else if (frame_event.ok) begin
         count_in = '0;
      end
   end

   assign lost = (count_in > timeout_ff);

   // held keys: loaded by a good frame, dropped while the link is lost
   always_comb begin
      held_in = held_ff;
      if (frame_event.ok) begin
         held_in = frame_event.word[KEY_W-1:0] & KEY_MASK;
      end
      if (lost) begin
         held_in = '0;
      end
   end

   // result item
   always_comb begin
      result.key_bits    = held_in;
      result.frame_ok    = frame_event.ok;
      result.check_error = frame_event.err;
      result.volume_up   = frame_event.ok & frame_event.word[VOL_UP_BIT];
      result.volume_down = frame_event.ok & frame_event.word[VOL_DOWN_BIT];
      result.mute_pulse  = frame_event.ok & frame_event.word[MUTE_BIT];
      result.link_lost   = lost;
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   // counter and keys
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
      end else if (step_en) begin
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

endmodule

@@ rtl/split_link_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// split_link_frame_receiver_unit
// Receives link bytes and time ticks, deframes sync/payload/check frames,
// holds the remote key bits and tracks link loss with a quiet counter.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid req_ready req_mode req_rx_byte | in
//   rsp     | rsp_valid rsp_ready rsp_key_bits, flags  | out
//   csr     | csr_valid csr_ready csr_wdata            | in
//
// One item per cycle sustained while rsp_ready holds; each item passes
// through the input register and then the result register.
// The frame and counter update is one short combinational pass between them.
// Reset is synchronous: hunting for sync, keys up, counter zero, timeout 100000.
// A stalled rsp side holds the result register; req keeps flowing until the
// input register also fills. csr writes are always taken.
// ----------------------------------------------------------------------------
module split_link_frame_receiver_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [slfr_pkg::KEY_W-1:0]     rsp_key_bits,
   output logic                           rsp_frame_ok,
   output logic                           rsp_check_error,
   output logic                           rsp_volume_up,
   output logic                           rsp_volume_down,
   output logic                           rsp_mute_pulse,
   output logic                           rsp_link_lost,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [slfr_pkg::COUNT_W-1:0]   csr_wdata
);
   import slfr_pkg::*;

   logic            in_valid_ff;
   logic            mode_ff;
   logic [7:0]      byte_ff;
   logic            rsp_valid_ff;
   result_type      result_ff, result_in;
   frame_event_type frame_event;
   logic            advance;

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         byte_ff <= req_rx_byte;
      end
   end

   // frame handling
   slfr_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .mode        (mode_ff),
      .rx_byte     (byte_ff),
      .frame_event (frame_event)
   );

   // keys, quiet counter, timeout
   slfr_key_hold u_key_hold (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .mode        (mode_ff),
      .frame_event (frame_event),
      .csr_we      (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .result      (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_bits    = result_ff.key_bits;
   assign rsp_frame_ok    = result_ff.frame_ok;
   assign rsp_check_error = result_ff.check_error;
   assign rsp_volume_up   = result_ff.volume_up;
   assign rsp_volume_down = result_ff.volume_down;
   assign rsp_mute_pulse  = result_ff.mute_pulse;
   assign rsp_link_lost   = result_ff.link_lost;

   // a lost link never shows held keys
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_link_lost) |-> (rsp_key_bits == '0))
      else $error("keys shown while link is lost");

   // pulses only come with a good frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_volume_up || rsp_volume_down || rsp_mute_pulse))
         |-> rsp_frame_ok)
      else $error("volume or mute pulse without a good frame");

   // a good frame restarts the counter, so the link is never lost with it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_ok) |-> !rsp_link_lost)
      else $error("link lost on a good frame");

   // a tick item never carries frame flags
   assert property (@(posedge clock) disable iff (reset)
      (advance && mode_ff == MODE_TICK) |=> (!rsp_frame_ok && !rsp_check_error))
      else $error("frame flag raised by a tick");

endmodule
